@@ design/iibs_pkg.sv @@
`timescale 1ns / 1ps

package iibs_pkg;

	// register indexes of the configuration port
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgDataW = 8;
	localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// reset values of the frame size registers
	localparam logic [7:0] IMAGE_WIDTH_RST = 8'd128;
	localparam logic [7:0] IMAGE_HEIGHT_RST = 8'd128;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_RANGE     = 2'd1,
		STS_OVERFLOW  = 2'd2,
		STS_NOT_READY = 2'd3
	} status_t;

	// corner read order of a box query
	typedef enum logic [1:0] {
		CORNER_BR    = 2'd0,
		CORNER_ABOVE = 2'd1,
		CORNER_LEFT  = 2'd2,
		CORNER_TL    = 2'd3
	} corner_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_Q_CHK,
		ST_Q_RD,
		ST_Q_DONE
	} state_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] pixel;
		logic [6:0] region_left;
		logic [6:0] region_top;
		logic [7:0] region_cols;
		logic [7:0] region_rows;
	} req_t;

	typedef struct packed {
		logic    capture;
		logic    pix_rd;
		logic    pix_wr;
		logic    q_chk;
		logic    q_rd;
		corner_t corner;
		logic    q_done;
	} cmd_t;

	typedef struct packed {
		logic out_stall;
		logic q_ok;
	} sts_t;

endpackage

@@ design/iibs_req_if.sv @@
`timescale 1ns / 1ps

interface iibs_req_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] pixel;
	logic [6:0] region_left;
	logic [6:0] region_top;
	logic [7:0] region_cols;
	logic [7:0] region_rows;

	modport source (
		output valid, operation, pixel, region_left, region_top, region_cols, region_rows,
		input  ready
	);
	modport sink (
		input  valid, operation, pixel, region_left, region_top, region_cols, region_rows,
		output ready
	);
endinterface

@@ design/iibs_rsp_if.sv @@
`timescale 1ns / 1ps

interface iibs_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] result_value;
	logic        frame_done;

	modport source (
		output valid, status, result_value, frame_done,
		input  ready
	);
	modport sink (
		input  valid, status, result_value, frame_done,
		output ready
	);
endinterface

@@ design/iibs_ctrl.sv @@
`timescale 1ns / 1ps

module iibs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_operation,
	output logic            in_ready,
	input  iibs_pkg::sts_t  sts,
	output iibs_pkg::cmd_t  cmd
);

	iibs_pkg::state_t  state_q, state_next;
	iibs_pkg::corner_t corner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= iibs_pkg::ST_IDLE;
			corner_q <= iibs_pkg::CORNER_BR;
		end else begin
			state_q <= state_next;
			if (state_q == iibs_pkg::ST_Q_RD)
				corner_q <= iibs_pkg::corner_t'(corner_q + 2'd1);
			else
				corner_q <= iibs_pkg::CORNER_BR;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			iibs_pkg::ST_IDLE: begin
				if (in_valid)
					state_next = (in_operation == iibs_pkg::OP_QUERY) ?
						iibs_pkg::ST_Q_CHK : iibs_pkg::ST_PIX_RD;
			end
			iibs_pkg::ST_PIX_RD: state_next = iibs_pkg::ST_PIX_WR;
			iibs_pkg::ST_PIX_WR: begin
				if (!sts.out_stall) state_next = iibs_pkg::ST_IDLE;
			end
			iibs_pkg::ST_Q_CHK: begin
				state_next = sts.q_ok ? iibs_pkg::ST_Q_RD : iibs_pkg::ST_Q_DONE;
			end
			iibs_pkg::ST_Q_RD: begin
				if (corner_q == iibs_pkg::CORNER_TL) state_next = iibs_pkg::ST_Q_DONE;
			end
			iibs_pkg::ST_Q_DONE: begin
				if (!sts.out_stall) state_next = iibs_pkg::ST_IDLE;
			end
			default: state_next = iibs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.corner = corner_q;
		in_ready   = 1'b0;
		case (state_q)
			iibs_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			iibs_pkg::ST_PIX_RD: cmd.pix_rd = 1'b1;
			iibs_pkg::ST_PIX_WR: cmd.pix_wr = !sts.out_stall;
			iibs_pkg::ST_Q_CHK:  cmd.q_chk = 1'b1;
			iibs_pkg::ST_Q_RD:   cmd.q_rd = 1'b1;
			iibs_pkg::ST_Q_DONE: cmd.q_done = !sts.out_stall;
			default: ;
		endcase
	end

endmodule

@@ design/iibs_datapath.sv @@
`timescale 1ns / 1ps

module iibs_datapath #(
	parameter int unsigned MAX_WIDTH = 128,
	parameter int unsigned MAX_HEIGHT = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [iibs_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [iibs_pkg::CfgDataW-1:0]      cfg_data,
	input  iibs_pkg::req_t                     req,
	input  iibs_pkg::cmd_t                     cmd,
	output iibs_pkg::sts_t                     sts,
	iibs_rsp_if.source                         response
);

	localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// dimension math also holds region_left + region_cols (9 bits)
	localparam int unsigned WDIM  = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
	localparam int unsigned HDIM  = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
	localparam int unsigned RAW   = $clog2(MAX_WIDTH * 255 + 1);

	function automatic logic [AW-1:0] tab_addr(input logic [CW-1:0] c, input logic [RW-1:0] r);
		return AW'(r) * AW'(MAX_WIDTH) + AW'(c);
	endfunction

	// table memory, single port, registered read
	logic [31:0]   mem [DEPTH];
	logic [AW-1:0] mem_addr;
	logic          mem_we, mem_re;
	logic [31:0]   mem_wdata, rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) rd_q <= mem[mem_addr];
	end

	// frame state
	logic [7:0]     img_w_q, img_h_q;
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [RAW-1:0] acc_q;
	logic           ready_q, ovf_q;

	// captured item
	iibs_pkg::req_t req_q;
	logic [CW-1:0]  x1_q, xm_q;
	logic [RW-1:0]  y1_q, ym_q;
	iibs_pkg::status_t qsts_q;
	logic [31:0]    sum_q;

	// output register
	logic           out_valid_q;
	logic [1:0]     out_status_q;
	logic [31:0]    out_value_q;
	logic           out_done_q;

	// clamped frame size
	logic [WDIM-1:0] w_raw, w_eff;
	logic [HDIM-1:0] h_raw, h_eff;

	always_comb begin
		w_raw = WDIM'(img_w_q);
		h_raw = HDIM'(img_h_q);
		if (w_raw == '0) w_eff = WDIM'(1);
		else if (w_raw > WDIM'(MAX_WIDTH)) w_eff = WDIM'(MAX_WIDTH);
		else w_eff = w_raw;
		if (h_raw == '0) h_eff = HDIM'(1);
		else if (h_raw > HDIM'(MAX_HEIGHT)) h_eff = HDIM'(MAX_HEIGHT);
		else h_eff = h_raw;
	end

	// pixel step
	logic           first_px, col_wrap, row_wrap, ovf_new;
	logic [RAW-1:0] acc_new;
	logic [32:0]    value;
	logic [RW-1:0]  row_m1;

	always_comb begin
		first_px = (col_q == '0) && (row_q == '0);
		acc_new  = ((col_q == '0) ? '0 : acc_q) + RAW'(req_q.pixel);
		value    = 33'(acc_new) + ((row_q == '0) ? 33'd0 : {1'b0, rd_q});
		ovf_new  = (first_px ? 1'b0 : ovf_q) | value[32];
		col_wrap = (WDIM'(col_q) + WDIM'(1)) >= w_eff;
		row_wrap = (HDIM'(row_q) + HDIM'(1)) >= h_eff;
		row_m1   = (row_q == '0) ? '0 : row_q - RW'(1);
	end

	// query check
	logic [8:0]        x_end, y_end;
	iibs_pkg::status_t qsts;
	logic              x0z, y0z;

	always_comb begin
		x_end = {2'b00, req_q.region_left} + {1'b0, req_q.region_cols};
		y_end = {2'b00, req_q.region_top} + {1'b0, req_q.region_rows};
		x0z   = (req_q.region_left == '0);
		y0z   = (req_q.region_top == '0);
		if (ovf_q) qsts = iibs_pkg::STS_OVERFLOW;
		else if (!ready_q) qsts = iibs_pkg::STS_NOT_READY;
		else if ((req_q.region_cols == '0) || (req_q.region_rows == '0) ||
		         (WDIM'(x_end) > w_eff) || (HDIM'(y_end) > h_eff))
			qsts = iibs_pkg::STS_RANGE;
		else qsts = iibs_pkg::STS_OK;
	end

	// corner term, zero where the corner lies outside the table
	logic [31:0] term;
	always_comb begin
		// term for a given read cycle comes from the previous corner
		case (cmd.corner)
			iibs_pkg::CORNER_LEFT: term = y0z ? 32'd0 : rd_q;  // above
			iibs_pkg::CORNER_TL:   term = x0z ? 32'd0 : rd_q;  // left
			default:               term = rd_q;
		endcase
	end

	// memory port
	always_comb begin
		mem_we    = cmd.pix_wr;
		mem_re    = cmd.pix_rd | cmd.q_rd;
		mem_wdata = value[31:0];
		mem_addr  = tab_addr(col_q, row_q);
		if (cmd.pix_rd) mem_addr = tab_addr(col_q, row_m1);
		else if (cmd.q_rd) begin
			case (cmd.corner)
				iibs_pkg::CORNER_BR:    mem_addr = tab_addr(x1_q, y1_q);
				iibs_pkg::CORNER_ABOVE: mem_addr = tab_addr(x1_q, ym_q);
				iibs_pkg::CORNER_LEFT:  mem_addr = tab_addr(xm_q, y1_q);
				iibs_pkg::CORNER_TL:    mem_addr = tab_addr(xm_q, ym_q);
				default:                mem_addr = tab_addr(x1_q, y1_q);
			endcase
		end
	end

	// frame state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= iibs_pkg::IMAGE_WIDTH_RST;
			img_h_q <= iibs_pkg::IMAGE_HEIGHT_RST;
			col_q   <= '0;
			row_q   <= '0;
			acc_q   <= '0;
			ready_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == iibs_pkg::REG_IMAGE_WIDTH) img_w_q <= cfg_data;
			if (cfg_index == iibs_pkg::REG_IMAGE_HEIGHT) img_h_q <= cfg_data;
			col_q   <= '0;
			row_q   <= '0;
			acc_q   <= '0;
			ready_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (cmd.pix_wr) begin
			acc_q <= acc_new;
			ovf_q <= ovf_new;
			if (first_px) ready_q <= 1'b0;
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q   <= '0;
					ready_q <= !ovf_new;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// item capture, corner setup and corner accumulation
	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= req;
		if (cmd.q_chk) begin
			qsts_q <= qsts;
			x1_q   <= CW'(x_end - 9'd1);
			y1_q   <= RW'(y_end - 9'd1);
			xm_q   <= x0z ? '0 : CW'({2'b00, req_q.region_left} - 9'd1);
			ym_q   <= y0z ? '0 : RW'({2'b00, req_q.region_top} - 9'd1);
		end
		if (cmd.q_rd) begin
			case (cmd.corner)
				iibs_pkg::CORNER_ABOVE: sum_q <= rd_q;
				iibs_pkg::CORNER_LEFT,
				iibs_pkg::CORNER_TL:    sum_q <= sum_q - term;
				default:                sum_q <= sum_q;
			endcase
		end
	end

	// output register
	logic [31:0] q_value;
	always_comb begin
		q_value = (qsts_q == iibs_pkg::STS_OK) ?
			sum_q + ((x0z | y0z) ? 32'd0 : rd_q) : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.pix_wr || cmd.q_done) out_valid_q <= 1'b1;
		else if (response.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_wr) begin
			out_status_q <= ovf_new ? iibs_pkg::STS_OVERFLOW : iibs_pkg::STS_OK;
			out_value_q  <= value[31:0];
			out_done_q   <= col_wrap & row_wrap;
		end else if (cmd.q_done) begin
			out_status_q <= qsts_q;
			out_value_q  <= q_value;
			out_done_q   <= 1'b0;
		end
	end

	assign response.valid        = out_valid_q;
	assign response.status       = out_status_q;
	assign response.result_value = out_value_q;
	assign response.frame_done   = out_done_q;

	assign sts.out_stall = out_valid_q & ~response.ready;
	assign sts.q_ok      = (qsts == iibs_pkg::STS_OK);

endmodule

@@ design/integral_image_box_sum.sv @@
`timescale 1ns / 1ps

// channel    modport  payload
// request    sink     operation, pixel, region_left, region_top, region_cols, region_rows
// response   source   status, result_value, frame_done
// cfg_*      write    cfg_we, cfg_index (0 width, 1 height), cfg_data
//
// A pixel item steps through accept, table read of the entry above, write and result.
// A box query steps through accept, range check, four corner reads through the single
// table port, result. A rejected query skips the corner reads.
// Reset clears the controller, frame counters and flags; the table holds garbage until
// rebuilt. A stalled response holds in its output register; the next item is accepted
// meanwhile and waits at its last step until the register frees.
module integral_image_box_sum #(
	parameter int unsigned MAX_WIDTH = 128,
	parameter int unsigned MAX_HEIGHT = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [iibs_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [iibs_pkg::CfgDataW-1:0] cfg_data,
	iibs_req_if.sink                      request,
	iibs_rsp_if.source                    response
);

	iibs_pkg::cmd_t cmd;
	iibs_pkg::sts_t sts;
	iibs_pkg::req_t req;
	logic           in_ready;

	// pack the request payload for the datapath capture register
	assign req.operation   = request.operation;
	assign req.pixel       = request.pixel;
	assign req.region_left = request.region_left;
	assign req.region_top  = request.region_top;
	assign req.region_cols = request.region_cols;
	assign req.region_rows = request.region_rows;
	assign request.ready   = in_ready;

	// sequencer: one item at a time, steps the single table port
	iibs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (request.valid),
		.in_operation (request.operation),
		.in_ready     (in_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// table memory, frame counters, corner arithmetic, output register
	iibs_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.response  (response)
	);

endmodule

@@ test/tb_integral_image_box_sum.sv @@
`timescale 1ns / 1ps

// Testbench for the integral image builder with box-sum queries.
// A scoreboard mirrors the summed-area table: every accepted pixel updates it and
// yields the expected integral entry; every query yields the expected box sum or
// the reason for rejecting it. Responses are checked in order, field by field.
module tb_integral_image_box_sum;

	localparam int MAX_W = 128;
	localparam int MAX_H = 128;
	localparam int RANDOM_ITEMS = 560;
	// leave room for a query to retire before a register write
	localparam int IDLE_SETTLE = 12;
	localparam int END_SETTLE = 40;
	// time limit for the whole run, well above the worst run
	localparam int RUN_LIMIT_NS = 1_000_000;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [iibs_pkg::CfgIdxW-1:0]  cfg_index;
	logic [iibs_pkg::CfgDataW-1:0] cfg_data;

	iibs_req_if req_ch ();
	iibs_rsp_if rsp_ch ();

	integral_image_box_sum #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.request (req_ch),
		.response(rsp_ch)
	);

	typedef struct packed {
		iibs_pkg::status_t status;
		logic [31:0]       value;
		logic              frame_done;
	} sum_result_t;

	// responses still owed by the block, oldest first
	sum_result_t awaited_sums[$];

	// mirror of the block state
	logic [31:0] sat_mem [MAX_W*MAX_H];
	logic [7:0]  width_reg;
	logic [7:0]  height_reg;
	logic [15:0] row_sum;
	int          next_col;
	int          next_row;
	bit          frame_ready;
	bit          frame_overflow;

	int items_sent;
	int pixels_sent;
	int queries_sent;
	int frames_built;
	int size_writes;
	int failures;
	int query_outcome [4];

	// sender shaping: steady_send disables gaps; burst_left counts down to the next gap
	bit steady_send;
	int burst_left;
	// receiver long hold-off, picked up and counted by the receiver process
	int stall_request;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("integral_image_box_sum regression: fail");
		$finish;
	end

	// ---------------------------------------------------------------- scoreboard

	// register value as the block uses it: zero acts as one, oversize as the maximum
	function automatic int eff_dim(logic [7:0] v, int limit);
		if (v == 8'd0)
			return 1;
		if (int'(v) > limit)
			return limit;
		return int'(v);
	endfunction

	function automatic void restart_frame();
		row_sum = '0;
		next_col = 0;
		next_row = 0;
		frame_ready = 1'b0;
		frame_overflow = 1'b0;
	endfunction

	// Advance the mirror by one accepted item and queue the response it must produce.
	function automatic void integrate_item(iibs_pkg::req_t it);
		int          w;
		int          h;
		int          x0;
		int          y0;
		int          cw;
		int          ch;
		int          x1;
		int          y1;
		logic [32:0] total;
		logic [31:0] br;
		logic [31:0] above;
		logic [31:0] left_sum;
		logic [31:0] tl;
		sum_result_t r;

		w = eff_dim(width_reg, MAX_W);
		h = eff_dim(height_reg, MAX_H);
		r.status = iibs_pkg::STS_OK;
		r.value = '0;
		r.frame_done = 1'b0;

		if (it.operation == iibs_pkg::OP_PIXEL) begin
			pixels_sent++;
			// first pixel of a frame: the table is rebuilt in place
			if (next_col == 0 && next_row == 0) begin
				frame_ready = 1'b0;
				frame_overflow = 1'b0;
			end
			if (next_col == 0)
				row_sum = '0;
			row_sum = row_sum + 16'(it.pixel);
			total = 33'(row_sum);
			if (next_row > 0)
				total = total + 33'(sat_mem[(next_row - 1) * MAX_W + next_col]);
			if (total[32])
				frame_overflow = 1'b1;
			sat_mem[next_row * MAX_W + next_col] = total[31:0];
			r.value = total[31:0];
			r.status = frame_overflow ? iibs_pkg::STS_OVERFLOW : iibs_pkg::STS_OK;
			if (next_col + 1 >= w) begin
				next_col = 0;
				if (next_row + 1 >= h) begin
					next_row = 0;
					r.frame_done = 1'b1;
					frame_ready = !frame_overflow;
					frames_built++;
				end else begin
					next_row++;
				end
			end else begin
				next_col++;
			end
		end else begin
			queries_sent++;
			x0 = int'(it.region_left);
			y0 = int'(it.region_top);
			cw = int'(it.region_cols);
			ch = int'(it.region_rows);
			if (frame_overflow) begin
				r.status = iibs_pkg::STS_OVERFLOW;
			end else if (!frame_ready) begin
				r.status = iibs_pkg::STS_NOT_READY;
			end else if (cw == 0 || ch == 0 || x0 + cw > w || y0 + ch > h) begin
				r.status = iibs_pkg::STS_RANGE;
			end else begin
				x1 = x0 + cw - 1;
				y1 = y0 + ch - 1;
				br = sat_mem[y1 * MAX_W + x1];
				above = '0;
				left_sum = '0;
				tl = '0;
				// corners above or left of the frame edge count as zero
				if (y0 > 0)
					above = sat_mem[(y0 - 1) * MAX_W + x1];
				if (x0 > 0)
					left_sum = sat_mem[y1 * MAX_W + x0 - 1];
				if (x0 > 0 && y0 > 0)
					tl = sat_mem[(y0 - 1) * MAX_W + x0 - 1];
				r.value = br + tl - above - left_sum;
			end
			query_outcome[r.status]++;
		end
		awaited_sums.push_back(r);
	endfunction

	// ---------------------------------------------------------------- response side

	// Receiver: segments of always-ready, coin-flip, mostly-ready and stalled,
	// overridden by a long hold-off when a test asks for one.
	initial begin
		int hold_left;
		int seg_left;
		int seg_kind;

		hold_left = 0;
		seg_left = 0;
		seg_kind = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request > 0) begin
				hold_left = stall_request;
				stall_request = 0;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				if (seg_left == 0) begin
					seg_kind = $urandom_range(0, 3);
					seg_left = $urandom_range(1, 24);
				end
				seg_left--;
				case (seg_kind)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					default: rsp_ch.ready <= 1'b0;
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_response
		sum_result_t want;

		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (awaited_sums.size() == 0) begin
				$error("response with nothing outstanding: status %0d value %0d done %0d",
					rsp_ch.status, rsp_ch.result_value, rsp_ch.frame_done);
				failures++;
			end else begin
				want = awaited_sums.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					failures++;
				end
				if (rsp_ch.result_value !== want.value) begin
					$error("result_value: expected %0d, got %0d", want.value,
						rsp_ch.result_value);
					failures++;
				end
				if (rsp_ch.frame_done !== want.frame_done) begin
					$error("frame_done: expected %0d, got %0d", want.frame_done,
						rsp_ch.frame_done);
					failures++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- request side

	// unused fields carry noise so the block must ignore them
	function automatic iibs_pkg::req_t pixel_item(logic [7:0] p);
		iibs_pkg::req_t it;

		it.operation = iibs_pkg::OP_PIXEL;
		it.pixel = p;
		it.region_left = 7'($urandom);
		it.region_top = 7'($urandom);
		it.region_cols = 8'($urandom);
		it.region_rows = 8'($urandom);
		return it;
	endfunction

	function automatic iibs_pkg::req_t query_item(int x0, int y0, int cw, int ch);
		iibs_pkg::req_t it;

		it.operation = iibs_pkg::OP_QUERY;
		it.pixel = 8'($urandom);
		it.region_left = 7'(x0);
		it.region_top = 7'(y0);
		it.region_cols = 8'(cw);
		it.region_rows = 8'(ch);
		return it;
	endfunction

	// in_pct of queries lie inside the frame; the rest are raw or one past the edge
	function automatic iibs_pkg::req_t random_query(int in_pct);
		int w;
		int h;
		int x0;
		int y0;

		w = eff_dim(width_reg, MAX_W);
		h = eff_dim(height_reg, MAX_H);
		x0 = $urandom_range(0, w - 1);
		y0 = $urandom_range(0, h - 1);
		if ($urandom_range(0, 99) < in_pct)
			return query_item(x0, y0, $urandom_range(1, w - x0), $urandom_range(1, h - y0));
		if ($urandom_range(0, 1) == 0)
			return query_item(x0, y0, w - x0 + $urandom_range(0, 1), h - y0 + 1);
		return query_item($urandom_range(0, 127), $urandom_range(0, 127),
			$urandom_range(0, 255), $urandom_range(0, 255));
	endfunction

	// Offer one item; called at a rising edge, returns at a rising edge.
	task automatic send_item(iibs_pkg::req_t it);
		req_ch.valid <= 1'b1;
		req_ch.operation <= it.operation;
		req_ch.pixel <= it.pixel;
		req_ch.region_left <= it.region_left;
		req_ch.region_top <= it.region_top;
		req_ch.region_cols <= it.region_cols;
		req_ch.region_rows <= it.region_rows;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		integrate_item(it);
		items_sent++;
		if (!steady_send) begin
			if (burst_left == 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(0, 12);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Pixels until the frame wraps, with queries sprinkled in at query_pct.
	// Style: 0 random, 1 all 255, 2 all 0, 3 bright.
	task automatic build_frame(int style, int query_pct);
		logic [7:0] p;

		do begin
			if ($urandom_range(0, 99) < query_pct)
				send_item(random_query(75));
			case (style)
				1: p = 8'd255;
				2: p = 8'd0;
				3: p = 8'($urandom_range(224, 255));
				default: p = 8'($urandom);
			endcase
			send_item(pixel_item(p));
		end while (!(next_col == 0 && next_row == 0));
	endtask

	// stop offering and let every owed response come back
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (awaited_sums.size() != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [iibs_pkg::CfgIdxW-1:0] idx, logic [7:0] val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == iibs_pkg::REG_IMAGE_WIDTH)
			width_reg = val;
		else
			height_reg = val;
		// any register write restarts the frame
		restart_frame();
		size_writes++;
	endtask

	// ---------------------------------------------------------------- tests

	// nothing is ready after reset, nor in the middle of the first frame
	task automatic test_after_reset();
		send_item(query_item(0, 0, 1, 1));
		send_item(pixel_item(8'd255));
		send_item(pixel_item(8'd0));
		send_item(query_item(0, 0, 128, 128));
		wait_idle();
	endtask

	// zero registers act as one: every pixel is a whole frame
	task automatic test_unit_frame();
		write_reg(iibs_pkg::REG_IMAGE_WIDTH, 8'd0);
		write_reg(iibs_pkg::REG_IMAGE_HEIGHT, 8'd0);
		send_item(pixel_item(8'd255));
		send_item(query_item(0, 0, 1, 1));
		send_item(query_item(0, 0, 0, 1));
		send_item(query_item(0, 0, 1, 0));
		send_item(query_item(0, 0, 2, 1));
		send_item(query_item(1, 0, 1, 1));
		send_item(query_item(0, 1, 1, 1));
		send_item(pixel_item(8'd0));
		send_item(query_item(0, 0, 1, 1));
		wait_idle();
	endtask

	// the four corner cases of the box sum, and loss of readiness on rebuild/rewrite
	task automatic test_box_corners();
		write_reg(iibs_pkg::REG_IMAGE_WIDTH, 8'd3);
		write_reg(iibs_pkg::REG_IMAGE_HEIGHT, 8'd2);
		build_frame(0, 0);
		send_item(query_item(0, 0, 3, 2));
		send_item(query_item(1, 1, 2, 1));
		send_item(query_item(2, 0, 1, 2));
		send_item(query_item(0, 1, 3, 1));
		send_item(query_item(1, 0, 3, 1));
		// new frame started: table no longer ready
		send_item(pixel_item(8'd17));
		send_item(query_item(0, 0, 1, 1));
		build_frame(0, 0);
		send_item(query_item(1, 0, 2, 2));
		// rewrite of the same value still restarts
		write_reg(iibs_pkg::REG_IMAGE_WIDTH, 8'd3);
		send_item(query_item(0, 0, 1, 1));
		wait_idle();
	endtask

	// full-width rows and full-height columns, with oversize register values
	task automatic test_dimension_extremes();
		write_reg(iibs_pkg::REG_IMAGE_WIDTH, 8'd128);
		write_reg(iibs_pkg::REG_IMAGE_HEIGHT, 8'd1);
		build_frame(1, 0);
		send_item(query_item(0, 0, 128, 1));
		send_item(query_item(127, 0, 1, 1));
		send_item(query_item(127, 0, 2, 1));
		send_item(query_item(0, 0, 128, 2));
		write_reg(iibs_pkg::REG_IMAGE_WIDTH, 8'd255);
		build_frame(3, 0);
		send_item(query_item(0, 0, 128, 1));
		repeat (2) send_item(random_query(100));
		write_reg(iibs_pkg::REG_IMAGE_WIDTH, 8'd1);
		write_reg(iibs_pkg::REG_IMAGE_HEIGHT, 8'd128);
		build_frame(0, 0);
		send_item(query_item(0, 127, 1, 1));
		send_item(query_item(0, 0, 1, 128));
		send_item(query_item(0, 64, 1, 64));
		send_item(query_item(0, 0, 1, 129));
		write_reg(iibs_pkg::REG_IMAGE_WIDTH, 8'd2);
		write_reg(iibs_pkg::REG_IMAGE_HEIGHT, 8'd255);
		build_frame(3, 5);
		send_item(query_item(1, 127, 1, 1));
		send_item(query_item(0, 0, 2, 128));
		wait_idle();
	endtask

	// receiver holds off long enough that the block fills and stalls its input
	task automatic test_output_backpressure();
		write_reg(iibs_pkg::REG_IMAGE_WIDTH, 8'd4);
		write_reg(iibs_pkg::REG_IMAGE_HEIGHT, 8'd4);
		steady_send = 1'b1;
		stall_request = 300;
		build_frame(0, 0);
		repeat (16) send_item(random_query(80));
		// sender pauses until everything has drained
		wait_idle();
	endtask

	// random frame sizes, frames with random content and random queries between them
	task automatic test_random_phases();
		int first_item;
		int shape;
		int w;
		int h;
		int frames;

		first_item = items_sent;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			shape = $urandom_range(0, 9);
			if (shape == 8) begin
				w = $urandom_range(100, 255);
				h = $urandom_range(0, 2);
			end else if (shape == 9) begin
				w = $urandom_range(0, 2);
				h = $urandom_range(100, 255);
			end else begin
				w = $urandom_range(0, 12);
				h = $urandom_range(0, 12);
			end
			case ($urandom_range(0, 5))
				0: write_reg(iibs_pkg::REG_IMAGE_WIDTH, 8'(w));
				1: write_reg(iibs_pkg::REG_IMAGE_HEIGHT, 8'(h));
				default: begin
					write_reg(iibs_pkg::REG_IMAGE_WIDTH, 8'(w));
					write_reg(iibs_pkg::REG_IMAGE_HEIGHT, 8'(h));
				end
			endcase
			w = eff_dim(width_reg, MAX_W);
			h = eff_dim(height_reg, MAX_H);
			steady_send = ($urandom_range(0, 3) == 0);
			frames = (shape >= 8) ? 1 : $urandom_range(1, 3);
			repeat ($urandom_range(0, 2)) send_item(random_query(75));
			repeat (frames) begin
				build_frame($urandom_range(0, 3), 10);
				repeat ($urandom_range(2, 10)) send_item(random_query(75));
			end
			// sometimes leave a frame half built before the next size change
			if (w * h > 1 && $urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, w * h - 1)) send_item(pixel_item(8'($urandom)));
				send_item(random_query(75));
			end
		end
		steady_send = 1'b0;
		wait_idle();
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = iibs_pkg::REG_IMAGE_WIDTH;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.operation = iibs_pkg::OP_PIXEL;
		req_ch.pixel = '0;
		req_ch.region_left = '0;
		req_ch.region_top = '0;
		req_ch.region_cols = '0;
		req_ch.region_rows = '0;
		steady_send = 1'b0;
		burst_left = 0;
		stall_request = 0;
		items_sent = 0;
		pixels_sent = 0;
		queries_sent = 0;
		frames_built = 0;
		size_writes = 0;
		failures = 0;
		query_outcome = '{default: 0};
		width_reg = iibs_pkg::IMAGE_WIDTH_RST;
		height_reg = iibs_pkg::IMAGE_HEIGHT_RST;
		restart_frame();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_unit_frame();
		test_box_corners();
		test_dimension_extremes();
		test_output_backpressure();
		test_random_phases();

		repeat (END_SETTLE) @(posedge clk);

		$display("covered %0d items (%0d pixels, %0d queries), %0d frames, %0d size writes",
			items_sent, pixels_sent, queries_sent, frames_built, size_writes);
		$display("query outcomes: %0d sums, %0d bad regions, %0d not ready, %0d overflow",
			query_outcome[iibs_pkg::STS_OK], query_outcome[iibs_pkg::STS_RANGE],
			query_outcome[iibs_pkg::STS_NOT_READY], query_outcome[iibs_pkg::STS_OVERFLOW]);
		if (failures == 0)
			$display("integral_image_box_sum regression: pass");
		else
			$display("integral_image_box_sum regression: fail");
		$finish;
	end

endmodule
